// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and constants for the i2c master register access block
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int BYTE_STORE_DEPTH = 32;
    localparam int ADDR_W  = $clog2(BYTE_STORE_DEPTH);
    localparam int DEPTH_W = $clog2(BYTE_STORE_DEPTH + 1);
    localparam int CNT_W   = (DEPTH_W > 7) ? DEPTH_W : 7;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BYTE_STORE_DEPTH);

    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_PUSH   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NACK   = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    localparam logic [15:0] QPT_RESET = 16'd100;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LOAD,
        PH_START,
        PH_TX_SET,
        PH_TX_HIGH,
        PH_TX_LOW,
        PH_ACK_HIGH,
        PH_ACK_SAMPLE,
        PH_RX_HIGH,
        PH_RX_LOW,
        PH_AO_DRIVE,
        PH_AO_HIGH,
        PH_AO_LOW,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_released;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       done_res;
        logic [1:0] status;
    } res_t;

endpackage

// File: rtl/i2cm_ram.sv
// ----------------------------------------------------------------------------
// i2cm_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module i2cm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// transaction sequencer: header and byte loading, prescaler and bus waveform
// ----------------------------------------------------------------------------
module i2cm_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [1:0]      opcode,
    input  logic [6:0]      device_address,
    input  logic            read_not_write,
    input  logic [5:0]      register_count,
    input  logic [5:0]      data_count,
    input  logic [7:0]      byte_value,
    input  logic            sda_in,
    input  logic [15:0]     qpt,
    output i2cm_pkg::res_t  res
);

    import i2cm_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [15:0]       presc_reg, presc_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [3:0]        bit_reg, bit_next;
    logic [7:0]        shift_reg, shift_next;
    logic [6:0]        addr_reg, addr_next;
    logic              dir_reg, dir_next;
    logic [5:0]        rc_reg, rc_next;
    logic [5:0]        dc_reg, dc_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              rel_reg, rel_next;
    logic              rdpart_reg, rdpart_next;

    logic              ram_we;
    logic [7:0]        ram_rdata;

    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  hdr_total;
    logic              hdr_bad;
    logic              rejected;
    logic [16:0]       presc_inc;
    logic [15:0]       q_eff;
    logic              running;
    logic              step;
    logic [CNT_W-1:0]  idx_inc;
    logic [3:0]        bit_inc;
    logic              last_byte;

    i2cm_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[ADDR_W-1:0]),
        .wdata (byte_value),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign total = dir_reg ? CNT_W'(rc_reg) : CNT_W'(rc_reg) + CNT_W'(dc_reg);
    assign hdr_total = read_not_write ? CNT_W'(register_count)
                                      : CNT_W'(register_count) + CNT_W'(data_count);
    assign hdr_bad = read_not_write
                   ? ((CNT_W'(register_count) > DEPTH_CNT) || (data_count == 6'd0))
                   : (hdr_total > DEPTH_CNT);
    assign rejected  = (opcode == OP_HEADER) && ((phase_reg != PH_IDLE) || hdr_bad);
    assign presc_inc = {1'b0, presc_reg} + 17'd1;
    assign q_eff     = (qpt == 16'd0) ? 16'd1 : qpt;
    assign running   = (phase_reg != PH_IDLE) && (phase_reg != PH_LOAD);
    assign step      = (opcode == OP_TICK) && running && (presc_inc >= {1'b0, q_eff});
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign bit_inc   = bit_reg + 4'd1;
    assign last_byte = idx_inc >= CNT_W'(dc_reg);

    // next state and datapath
    always_comb
    begin
        phase_next  = phase_reg;
        presc_next  = presc_reg;
        idx_next    = idx_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        addr_next   = addr_reg;
        dir_next    = dir_reg;
        rc_next     = rc_reg;
        dc_next     = dc_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        rel_next    = rel_reg;
        rdpart_next = rdpart_reg;
        ram_we      = 1'b0;

        unique case (opcode)
            OP_HEADER:
            begin
                if (!rejected)
                begin
                    addr_next = device_address;
                    dir_next  = read_not_write;
                    rc_next   = register_count;
                    dc_next   = data_count;
                    idx_next  = '0;
                    if (hdr_total == '0)
                    begin
                        phase_next  = PH_START;
                        bit_next    = 4'd0;
                        presc_next  = 16'd0;
                        rdpart_next = read_not_write && (register_count == 6'd0);
                    end
                    else
                    begin
                        phase_next = PH_LOAD;
                    end
                end
            end
            OP_PUSH:
            begin
                if (phase_reg == PH_LOAD)
                begin
                    ram_we   = in_fire;
                    idx_next = idx_inc;
                    if (idx_inc >= total)
                    begin
                        phase_next  = PH_START;
                        bit_next    = 4'd0;
                        idx_next    = '0;
                        presc_next  = 16'd0;
                        rdpart_next = dir_reg && (rc_reg == 6'd0);
                    end
                end
            end
            OP_TICK:
            begin
                if (running)
                begin
                    if (step)
                    begin
                        presc_next = 16'd0;
                    end
                    else
                    begin
                        presc_next = presc_inc[15:0];
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (step)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    case (bit_reg)
                        4'd0:    sda_next = 1'b1;
                        4'd1:    scl_next = 1'b1;
                        4'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                    bit_next = bit_inc;
                    if (bit_inc >= 4'd4)
                    begin
                        shift_next = {addr_reg, rdpart_reg};
                        bit_next   = 4'd0;
                        phase_next = PH_TX_SET;
                    end
                end
                PH_TX_SET:
                begin
                    sda_next   = shift_reg[7];
                    phase_next = PH_TX_HIGH;
                end
                PH_TX_HIGH:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_TX_LOW;
                end
                PH_TX_LOW:
                begin
                    scl_next   = 1'b0;
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next   = bit_inc;
                    phase_next = (bit_inc >= 4'd8) ? PH_ACK_HIGH : PH_TX_SET;
                end
                PH_ACK_HIGH:
                begin
                    sda_next   = 1'b1;
                    rel_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = PH_ACK_SAMPLE;
                end
                PH_ACK_SAMPLE:
                begin
                    scl_next = 1'b0;
                    rel_next = 1'b0;
                    if (sda_in)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (!dir_reg || !rdpart_reg)
                    begin
                        if (idx_reg < total)
                        begin
                            shift_next = ram_rdata;
                            idx_next   = idx_inc;
                            bit_next   = 4'd0;
                            phase_next = PH_TX_SET;
                        end
                        else if (!dir_reg)
                        begin
                            phase_next = PH_STOP;
                            bit_next   = 4'd0;
                        end
                        else
                        begin
                            rdpart_next = 1'b1;
                            phase_next  = PH_START;
                            bit_next    = 4'd0;
                        end
                    end
                    else
                    begin
                        idx_next   = '0;
                        bit_next   = 4'd0;
                        shift_next = 8'd0;
                        phase_next = PH_RX_HIGH;
                    end
                end
                PH_RX_HIGH:
                begin
                    sda_next   = 1'b1;
                    rel_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = PH_RX_LOW;
                end
                PH_RX_LOW:
                begin
                    shift_next = {shift_reg[6:0], sda_in};
                    scl_next   = 1'b0;
                    bit_next   = bit_inc;
                    phase_next = (bit_inc >= 4'd8) ? PH_AO_DRIVE : PH_RX_HIGH;
                end
                PH_AO_DRIVE:
                begin
                    rel_next   = 1'b0;
                    sda_next   = last_byte;
                    phase_next = PH_AO_HIGH;
                end
                PH_AO_HIGH:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_AO_LOW;
                end
                PH_AO_LOW:
                begin
                    scl_next   = 1'b0;
                    idx_next   = idx_inc;
                    bit_next   = 4'd0;
                    shift_next = 8'd0;
                    phase_next = last_byte ? PH_STOP : PH_RX_HIGH;
                end
                PH_STOP:
                begin
                    case (bit_reg)
                        4'd0:    sda_next = 1'b0;
                        4'd1:    scl_next = 1'b1;
                        4'd2:    sda_next = 1'b1;
                        default: phase_next = PH_IDLE;
                    endcase
                    bit_next = bit_inc;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result item
    always_comb
    begin
        res              = '0;
        res.scl_level    = scl_next;
        res.sda_level    = sda_next;
        res.sda_released = rel_next;
        if (rejected)
        begin
            res.done_res = 1'b1;
            res.status   = STATUS_REJECT;
        end
        else if (step && (phase_reg == PH_ACK_SAMPLE) && sda_in)
        begin
            res.done_res = 1'b1;
            res.status   = STATUS_NACK;
        end
        else if (step && (phase_reg == PH_STOP) && (bit_reg >= 4'd3))
        begin
            res.done_res = 1'b1;
            res.status   = STATUS_OK;
        end
        else if (step && (phase_reg == PH_RX_LOW) && (bit_inc >= 4'd8))
        begin
            res.read_valid = 1'b1;
            res.read_data  = {shift_reg[6:0], sda_in};
            res.read_last  = last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            presc_reg  <= 16'd0;
            idx_reg    <= '0;
            bit_reg    <= 4'd0;
            shift_reg  <= 8'd0;
            addr_reg   <= 7'd0;
            dir_reg    <= 1'b0;
            rc_reg     <= 6'd0;
            dc_reg     <= 6'd0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            rel_reg    <= 1'b0;
            rdpart_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            presc_reg  <= presc_next;
            idx_reg    <= idx_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            addr_reg   <= addr_next;
            dir_reg    <= dir_next;
            rc_reg     <= rc_next;
            dc_reg     <= dc_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            rel_reg    <= rel_next;
            rdpart_reg <= rdpart_next;
        end
    end

endmodule

// File: rtl/i2cm_out_buf.sv
// ----------------------------------------------------------------------------
// i2cm_out_buf
// output register with one skid entry so one more request is taken under stall
// ----------------------------------------------------------------------------
module i2cm_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2cm_pkg::res_t  push_data,
    output logic            push_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output i2cm_pkg::res_t  out_data
);

    import i2cm_pkg::*;

    logic  out_valid_reg;
    logic  skid_valid_reg;
    res_t  out_reg;
    res_t  skid_reg;
    logic  pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                out_reg <= push_data;
            end
        end
    end

endmodule

// File: rtl/i2c_master_register_access_top.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access_top
// i2c master running register write and register read transactions
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while the output buffer has room, and each
// request gives exactly one result; a request is fully handled in the cycle it is
// accepted and its result is registered in a two-entry output buffer, which lets
// one more request be taken while results stall.
// A header request loads address, direction and counts, push requests fill
// the byte store (one write port, one registered read port), and tick
// requests move the bus waveform one step every quarter_period_ticks ticks.
// The byte store needs no clearing after reset. cfg_ready is always high;
// write quarter_period_ticks only while no transaction is in flight.
module i2c_master_register_access_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [6:0]  device_address,
    input  logic        read_not_write,
    input  logic [5:0]  register_count,
    input  logic [5:0]  data_count,
    input  logic [7:0]  byte_value,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_level,
    output logic        sda_level,
    output logic        sda_released,
    output logic        read_valid,
    output logic [7:0]  read_data,
    output logic        read_last,
    output logic        done_res,
    output logic [1:0]  status
);

    import i2cm_pkg::*;

    logic [15:0] qpt_reg;
    logic        in_fire;
    res_t        res;
    res_t        out_data;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpt_reg <= QPT_RESET;
        end
        else if (cfg_valid)
        begin
            qpt_reg <= cfg_data;
        end
    end

    i2cm_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .opcode         (opcode),
        .device_address (device_address),
        .read_not_write (read_not_write),
        .register_count (register_count),
        .data_count     (data_count),
        .byte_value     (byte_value),
        .sda_in         (sda_in),
        .qpt            (qpt_reg),
        .res            (res)
    );

    i2cm_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_fire),
        .push_data  (res),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign scl_level    = out_data.scl_level;
    assign sda_level    = out_data.sda_level;
    assign sda_released = out_data.sda_released;
    assign read_valid   = out_data.read_valid;
    assign read_data    = out_data.read_data;
    assign read_last    = out_data.read_last;
    assign done_res     = out_data.done_res;
    assign status       = out_data.status;

endmodule

// File: rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       sda_level,
    input logic       sda_released,
    input logic       read_valid,
    input logic [7:0] read_data,
    input logic       read_last,
    input logic       done_res,
    input logic [1:0] status
);

    import i2cm_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
        else $error("stalled result changed");

    // a received byte and a completion never share one result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(read_valid && done_res))
        else $error("read byte and done in one result");

    // status only with done
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> status == STATUS_OK)
        else $error("status without done");

    // last marker only on a received byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_last |-> read_valid)
        else $error("read_last without read_valid");

    // released sda is left high on the driver side
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sda_released |-> sda_level)
        else $error("sda released while driven low");

endmodule

bind i2c_master_register_access_top i2cm_checker u_i2cm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sda_level    (sda_level),
    .sda_released (sda_released),
    .read_valid   (read_valid),
    .read_data    (read_data),
    .read_last    (read_last),
    .done_res     (done_res),
    .status       (status)
);

// File: dv/i2cm_bus_checker.sv
// ----------------------------------------------------------------------------
// i2cm_bus_checker
// predicts every accepted request of the i2c master and compares the results
// ----------------------------------------------------------------------------
module i2cm_bus_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [15:0]      cfg_data,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [1:0]       opcode,
    input  logic [6:0]       device_address,
    input  logic             read_not_write,
    input  logic [5:0]       register_count,
    input  logic [5:0]       data_count,
    input  logic [7:0]       byte_value,
    input  logic             sda_in,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic             scl_level,
    input  logic             sda_level,
    input  logic             sda_released,
    input  logic             read_valid,
    input  logic [7:0]       read_data,
    input  logic             read_last,
    input  logic             done_res,
    input  logic [1:0]       status,
    output int               fail_count,
    output int               pending,
    output i2cm_pkg::phase_t bus_phase
);

    import i2cm_pkg::*;

    logic [15:0] quarter_period;
    phase_t      phase;
    int unsigned prescale;
    logic [7:0]  byte_mem [BYTE_STORE_DEPTH];
    int unsigned byte_pos;
    int unsigned bit_pos;
    logic [7:0]  shifter;
    logic [6:0]  target_addr;
    logic        is_read;
    int unsigned reg_bytes;
    int unsigned data_bytes;
    logic        scl_q;
    logic        sda_q;
    logic        sda_rel_q;
    logic        in_read_part;
    res_t        step_res;
    res_t        want;
    res_t        bus_result_q [$];

    function automatic int unsigned stored_total();
        return is_read ? reg_bytes : reg_bytes + data_bytes;
    endfunction

    task automatic begin_bus_start();
        phase        = PH_START;
        bit_pos      = 0;
        byte_pos     = 0;
        prescale     = 0;
        in_read_part = is_read && (reg_bytes == 0);
    endtask

    task automatic load_next_byte();
        shifter  = (byte_pos < BYTE_STORE_DEPTH) ? byte_mem[byte_pos] : 8'h00;
        byte_pos = byte_pos + 1;
        bit_pos  = 0;
        phase    = PH_TX_SET;
    endtask

    task automatic advance_waveform(input logic sda_sample);
        case (phase)
            PH_START:
            begin
                case (bit_pos)
                    0:       sda_q = 1'b1;
                    1:       scl_q = 1'b1;
                    2:       sda_q = 1'b0;
                    default: scl_q = 1'b0;
                endcase
                bit_pos = bit_pos + 1;
                if (bit_pos >= 4)
                begin
                    shifter = {target_addr, in_read_part};
                    bit_pos = 0;
                    phase   = PH_TX_SET;
                end
            end
            PH_TX_SET:
            begin
                sda_q = shifter[7];
                phase = PH_TX_HIGH;
            end
            PH_TX_HIGH:
            begin
                scl_q = 1'b1;
                phase = PH_TX_LOW;
            end
            PH_TX_LOW:
            begin
                scl_q   = 1'b0;
                shifter = shifter << 1;
                bit_pos = bit_pos + 1;
                if (bit_pos >= 8)
                    phase = PH_ACK_HIGH;
                else
                    phase = PH_TX_SET;
            end
            PH_ACK_HIGH:
            begin
                sda_q     = 1'b1;
                sda_rel_q = 1'b1;
                scl_q     = 1'b1;
                phase     = PH_ACK_SAMPLE;
            end
            PH_ACK_SAMPLE:
            begin
                scl_q     = 1'b0;
                sda_rel_q = 1'b0;
                if (sda_sample)
                begin
                    step_res.done_res = 1'b1;
                    step_res.status   = STATUS_NACK;
                    phase             = PH_IDLE;
                end
                else if (!is_read)
                begin
                    if (byte_pos < stored_total())
                        load_next_byte();
                    else
                    begin
                        phase   = PH_STOP;
                        bit_pos = 0;
                    end
                end
                else if (!in_read_part)
                begin
                    if (byte_pos < reg_bytes)
                        load_next_byte();
                    else
                    begin
                        // repeated start for the read part
                        in_read_part = 1'b1;
                        phase        = PH_START;
                        bit_pos      = 0;
                    end
                end
                else
                begin
                    byte_pos = 0;
                    bit_pos  = 0;
                    shifter  = 8'h00;
                    phase    = PH_RX_HIGH;
                end
            end
            PH_RX_HIGH:
            begin
                sda_q     = 1'b1;
                sda_rel_q = 1'b1;
                scl_q     = 1'b1;
                phase     = PH_RX_LOW;
            end
            PH_RX_LOW:
            begin
                shifter = {shifter[6:0], sda_sample};
                scl_q   = 1'b0;
                bit_pos = bit_pos + 1;
                if (bit_pos >= 8)
                begin
                    step_res.read_valid = 1'b1;
                    step_res.read_data  = shifter;
                    step_res.read_last  = (byte_pos + 1 >= data_bytes);
                    phase               = PH_AO_DRIVE;
                end
                else
                    phase = PH_RX_HIGH;
            end
            PH_AO_DRIVE:
            begin
                sda_rel_q = 1'b0;
                sda_q     = (byte_pos + 1 >= data_bytes);
                phase     = PH_AO_HIGH;
            end
            PH_AO_HIGH:
            begin
                scl_q = 1'b1;
                phase = PH_AO_LOW;
            end
            PH_AO_LOW:
            begin
                scl_q    = 1'b0;
                byte_pos = byte_pos + 1;
                bit_pos  = 0;
                shifter  = 8'h00;
                if (byte_pos < data_bytes)
                    phase = PH_RX_HIGH;
                else
                    phase = PH_STOP;
            end
            PH_STOP:
            begin
                case (bit_pos)
                    0:       sda_q = 1'b0;
                    1:       scl_q = 1'b1;
                    2:       sda_q = 1'b1;
                    default:
                    begin
                        step_res.done_res = 1'b1;
                        step_res.status   = STATUS_OK;
                        phase             = PH_IDLE;
                    end
                endcase
                bit_pos = bit_pos + 1;
            end
            default: ;
        endcase
    endtask

    task automatic predict_bus_step();
        logic        bad;
        int unsigned period;
        step_res = '0;
        case (opcode)
            OP_HEADER:
            begin
                if (read_not_write)
                    bad = (int'(register_count) > BYTE_STORE_DEPTH) || (data_count == 0);
                else
                    bad = (int'(register_count) + int'(data_count) > BYTE_STORE_DEPTH);
                if (phase != PH_IDLE || bad)
                begin
                    step_res.done_res = 1'b1;
                    step_res.status   = STATUS_REJECT;
                end
                else
                begin
                    target_addr = device_address;
                    is_read     = read_not_write;
                    reg_bytes   = 32'(register_count);
                    data_bytes  = 32'(data_count);
                    byte_pos    = 0;
                    if (stored_total() == 0)
                        begin_bus_start();
                    else
                        phase = PH_LOAD;
                end
            end
            OP_PUSH:
            begin
                if (phase == PH_LOAD)
                begin
                    if (byte_pos < BYTE_STORE_DEPTH)
                        byte_mem[byte_pos] = byte_value;
                    byte_pos = byte_pos + 1;
                    if (byte_pos >= stored_total())
                        begin_bus_start();
                end
            end
            OP_TICK:
            begin
                if (phase != PH_IDLE && phase != PH_LOAD)
                begin
                    period = (quarter_period == 0) ? 1 : quarter_period;
                    if (prescale + 1 >= period)
                    begin
                        prescale = 0;
                        advance_waveform(sda_in);
                    end
                    else
                        prescale = prescale + 1;
                end
            end
            default: ;
        endcase
        step_res.scl_level    = scl_q;
        step_res.sda_level    = sda_q;
        step_res.sda_released = sda_rel_q;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quarter_period = QPT_RESET;
            phase          = PH_IDLE;
            prescale       = 0;
            byte_pos       = 0;
            bit_pos        = 0;
            shifter        = 8'h00;
            target_addr    = 7'h00;
            is_read        = 1'b0;
            reg_bytes      = 0;
            data_bytes     = 0;
            scl_q          = 1'b1;
            sda_q          = 1'b1;
            sda_rel_q      = 1'b0;
            in_read_part   = 1'b0;
            bus_result_q.delete();
            fail_count     = 0;
            pending        = 0;
            bus_phase      = PH_IDLE;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (bus_result_q.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, expected none, got %h",
                             $time, {scl_level, sda_level, sda_released, read_valid,
                                     read_data, read_last, done_res, status});
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = bus_result_q.pop_front();
                    check_field("scl_level", 8'(want.scl_level), 8'(scl_level));
                    check_field("sda_level", 8'(want.sda_level), 8'(sda_level));
                    check_field("sda_released", 8'(want.sda_released), 8'(sda_released));
                    check_field("read_valid", 8'(want.read_valid), 8'(read_valid));
                    check_field("read_data", want.read_data, read_data);
                    check_field("read_last", 8'(want.read_last), 8'(read_last));
                    check_field("done_res", 8'(want.done_res), 8'(done_res));
                    check_field("status", 8'(want.status), 8'(status));
                end
            end
            if (cfg_valid && cfg_ready)
                quarter_period = cfg_data;
            if (in_valid && in_ready)
            begin
                predict_bus_step();
                bus_result_q.push_back(step_res);
            end
            pending   = bus_result_q.size();
            bus_phase = phase;
        end
    end

endmodule

// File: dv/i2c_master_register_access_top_test.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access_top_test
// random and directed header, push and tick requests under idling and stalls
// ----------------------------------------------------------------------------
module i2c_master_register_access_top_test;
    import i2cm_pkg::*;

    localparam logic [1:0] OP_RESERVED      = 2'd3;
    localparam int         WATCHDOG_LIMIT   = 4000;
    localparam int         SINK_HOLD_CYCLES = 300;
    localparam int         PHASE_ITEMS      = 60;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [6:0]  device_address;
    logic        read_not_write;
    logic [5:0]  register_count;
    logic [5:0]  data_count;
    logic [7:0]  byte_value;
    logic        sda_in;
    logic        out_valid;
    logic        out_ready;
    logic        scl_level;
    logic        sda_level;
    logic        sda_released;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        read_last;
    logic        done_res;
    logic [1:0]  status;

    int          fail_count;
    int          remaining;
    phase_t      bus_phase;
    logic        calm;
    logic        sink_hold_req;
    int          sent_items;

    i2c_master_register_access_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .device_address (device_address),
        .read_not_write (read_not_write),
        .register_count (register_count),
        .data_count     (data_count),
        .byte_value     (byte_value),
        .sda_in         (sda_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .scl_level      (scl_level),
        .sda_level      (sda_level),
        .sda_released   (sda_released),
        .read_valid     (read_valid),
        .read_data      (read_data),
        .read_last      (read_last),
        .done_res       (done_res),
        .status         (status)
    );

    i2cm_bus_checker bus_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .device_address (device_address),
        .read_not_write (read_not_write),
        .register_count (register_count),
        .data_count     (data_count),
        .byte_value     (byte_value),
        .sda_in         (sda_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .scl_level      (scl_level),
        .sda_level      (sda_level),
        .sda_released   (sda_released),
        .read_valid     (read_valid),
        .read_data      (read_data),
        .read_last      (read_last),
        .done_res       (done_res),
        .status         (status),
        .fail_count     (fail_count),
        .pending        (remaining),
        .bus_phase      (bus_phase)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_item(input logic [1:0] op, input logic [6:0] addr, input logic dir,
                             input logic [5:0] rcnt, input logic [5:0] dcnt,
                             input logic [7:0] bval, input logic sdi);
        if (!calm && $urandom_range(99) < 35)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        opcode         = op;
        device_address = addr;
        read_not_write = dir;
        register_count = rcnt;
        data_count     = dcnt;
        byte_value     = bval;
        sda_in         = sdi;
        in_valid       = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent_items = sent_items + 1;
    endtask

    task automatic send_rand(input logic [1:0] op, input logic sdi);
        send_item(op, 7'($urandom), 1'($urandom), 6'($urandom), 6'($urandom),
                  8'($urandom), sdi);
    endtask

    task automatic send_noise(input logic allow_push);
        int pick;
        pick = $urandom_range(allow_push ? 3 : 2);
        case (pick)
            0:       send_rand(OP_HEADER, 1'($urandom));
            1:       send_rand(OP_RESERVED, 1'($urandom));
            2:       send_rand(OP_TICK, 1'($urandom));
            default: send_rand(OP_PUSH, 1'($urandom));
        endcase
    endtask

    // tick until the bus is idle again, target nacks on acknowledge number nack_at
    task automatic finish_bus(input int nack_at, input int noise_pct);
        int     ack_no;
        logic   nack;
        phase_t seen;
        ack_no = -1;
        nack   = 1'b0;
        seen   = PH_IDLE;
        while (bus_phase != PH_IDLE)
        begin
            if (bus_phase == PH_ACK_SAMPLE && seen != PH_ACK_SAMPLE)
            begin
                ack_no = ack_no + 1;
                nack   = (ack_no == nack_at);
            end
            seen = bus_phase;
            if (bus_phase == PH_LOAD)
                send_rand(OP_PUSH, 1'($urandom));
            else if ($urandom_range(99) < noise_pct)
                send_noise(1'b1);
            else if (bus_phase == PH_ACK_SAMPLE)
                send_rand(OP_TICK, nack);
            else
                send_rand(OP_TICK, 1'($urandom));
        end
    endtask

    task automatic run_transfer(input logic [6:0] addr, input logic dir, input int rcnt,
                                input int dcnt, input int nack_at, input int noise_pct);
        int total;
        total = dir ? rcnt : rcnt + dcnt;
        send_item(OP_HEADER, addr, dir, 6'(rcnt), 6'(dcnt), 8'($urandom), 1'($urandom));
        for (int k = 0; k < total; k++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_noise(1'b0);
            send_rand(OP_PUSH, 1'($urandom));
        end
        finish_bus(nack_at, noise_pct);
    endtask

    task automatic random_transfer();
        int   rcnt;
        int   dcnt;
        int   nack_at;
        logic dir;
        dir     = 1'($urandom);
        nack_at = ($urandom_range(1) == 0) ? int'($urandom_range(0, 2)) : -1;
        rcnt    = $urandom_range(0, 2);
        dcnt    = $urandom_range(dir ? 1 : 0, 2);
        run_transfer(7'($urandom), dir, rcnt, dcnt, nack_at, 5);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (remaining != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_quarter_period(input logic [15:0] period);
        drain_results();
        cfg_data  = period;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random_phase(input logic [15:0] period, input logic with_hold,
                                    input logic quiet);
        int stop_at;
        set_quarter_period(period);
        calm    = quiet;
        stop_at = sent_items + PHASE_ITEMS;
        if (with_hold)
            sink_hold_req = 1'b1;
        while (sent_items < stop_at)
            random_transfer();
        calm = 1'b0;
    endtask

    // result side: random back-pressure plus one long hold-off
    initial
    begin
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left = hold_left - 1;
            end
            else if (sink_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = SINK_HOLD_CYCLES - 1;
                out_ready = 1'b0;
            end
            else if (!calm && $urandom_range(99) < 35)
                out_ready = 1'b0;
            else
                out_ready = 1'b1;
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** i2c_master_register_access_top: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 16'h0000;
        in_valid       = 1'b0;
        opcode         = OP_TICK;
        device_address = 7'h00;
        read_not_write = 1'b0;
        register_count = 6'd0;
        data_count     = 6'd0;
        byte_value     = 8'h00;
        sda_in         = 1'b1;
        calm           = 1'b0;
        sink_hold_req  = 1'b0;
        sent_items     = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // idle-state corner cases at the reset period
        send_item(OP_PUSH, 7'h00, 1'b0, 6'd0, 6'd0, 8'hA5, 1'b0);
        send_item(OP_TICK, 7'h00, 1'b0, 6'd0, 6'd0, 8'h00, 1'b1);
        send_item(OP_RESERVED, 7'h7F, 1'b1, 6'h3F, 6'h3F, 8'hFF, 1'b1);
        send_item(OP_HEADER, 7'h12, 1'b0, 6'd32, 6'd1, 8'h00, 1'b0);
        send_item(OP_HEADER, 7'h12, 1'b1, 6'd1, 6'd0, 8'h00, 1'b0);
        send_item(OP_HEADER, 7'h12, 1'b1, 6'd33, 6'd1, 8'h00, 1'b0);
        send_item(OP_HEADER, 7'h7F, 1'b0, 6'h3F, 6'h3F, 8'h00, 1'b0);

        // busy header while loading, stray push while running
        set_quarter_period(16'd1);
        send_item(OP_HEADER, 7'h7F, 1'b0, 6'd0, 6'd1, 8'h00, 1'b0);
        send_item(OP_HEADER, 7'h01, 1'b0, 6'd0, 6'd0, 8'h00, 1'b0);
        send_item(OP_PUSH, 7'h00, 1'b0, 6'd0, 6'd0, 8'hFF, 1'b0);
        send_item(OP_PUSH, 7'h00, 1'b0, 6'd0, 6'd0, 8'h00, 1'b0);
        finish_bus(-1, 0);
        run_transfer(7'h55, 1'b1, 1, 2, -1, 0);
        run_transfer(7'h2A, 1'b0, 0, 1, 1, 0);
        run_transfer(7'h00, 1'b1, 0, 1, 0, 0);

        run_random_phase(16'd2, 1'b1, 1'b0);
        run_random_phase(16'd0, 1'b0, 1'b1);
        run_random_phase(16'd1, 1'b0, 1'b0);

        in_valid = 1'b0;
        while (remaining != 0) @(negedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && remaining == 0)
            $display("** i2c_master_register_access_top: PASSED **");
        else
            $display("** i2c_master_register_access_top: FAILED **");
        $finish;
    end

endmodule

// File: files.f
rtl/i2cm_pkg.sv
rtl/i2cm_ram.sv
rtl/i2cm_engine.sv
rtl/i2cm_out_buf.sv
rtl/i2c_master_register_access_top.sv
rtl/i2cm_checker.sv
dv/i2cm_bus_checker.sv
dv/i2c_master_register_access_top_test.sv
